[rtl/scl_pkg.sv]
// scl_pkg: shared types and constants for the slot cache lru lookup block
// holds cache geometry, request/response payload structs and control structs
// no dependencies
package scl_pkg;

    // cache geometry
    localparam int CACHE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int ENTRY_IDX_W   = 6;
    localparam int COORD_W       = 16;
    localparam int STAMP_W       = 32;

    // request payload
    typedef struct packed {
        logic signed [COORD_W-1:0] slot_x;
        logic signed [COORD_W-1:0] slot_z;
        logic        [STAMP_W-1:0] frame_number;
    } t_req;

    // response payload
    typedef struct packed {
        logic                   hit;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic                   fill_needed;
        logic                   evicted_valid;
    } t_rsp;

    // one stored cache entry
    typedef struct packed {
        logic [COORD_W-1:0] tag_x;
        logic [COORD_W-1:0] tag_z;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic issue;
        logic update;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_issue;
    } t_ctl_sts;

endpackage

[rtl/slot_cache_lru_lookup.sv]
// slot_cache_lru_lookup: fully associative slot tag cache with frame-stamp lru
// a lookup latches the query, scans all entries one entry per cycle through the
// single read port of the entry memory, drains the read pipeline, then writes the
// chosen entry and registers the result strobe; no new start is taken while busy
// reset: synchronous, clears all valid bits at once, no clearing pass
// the receiver cannot stall; a new start may be taken in the strobe cycle
module slot_cache_lru_lookup (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  scl_pkg::t_req i_req,
    output logic          o_valid,
    output scl_pkg::t_rsp o_rsp
);

    scl_pkg::t_ctl_cmd w_cmd;
    scl_pkg::t_ctl_sts w_sts;

    // sequencer
    scl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // entry storage and scan datapath
    scl_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

[rtl/scl_ctrl.sv]
// scl_ctrl: lookup sequencer for the slot cache
// steps through load, scan, drain and update phases
// depends on scl_pkg
module scl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  scl_pkg::t_ctl_sts i_sts,
    output scl_pkg::t_ctl_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.update = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

[rtl/scl_dpath.sv]
// scl_dpath: entry memory, scan pipeline, match and oldest-stamp tracking
// one entry is read per cycle; the chosen entry is written on update
// depends on scl_pkg
module scl_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scl_pkg::t_ctl_cmd i_cmd,
    output scl_pkg::t_ctl_sts o_sts,
    input  scl_pkg::t_req     i_req,
    output logic              o_valid,
    output scl_pkg::t_rsp     o_rsp
);

    // entry memory and valid bits
    scl_pkg::t_entry r_mem [scl_pkg::CACHE_ENTRIES];
    logic [scl_pkg::CACHE_ENTRIES-1:0] r_ent_vld;

    // latched query
    scl_pkg::t_req r_req;

    // read pipeline
    logic [scl_pkg::IDX_W-1:0] r_addr;
    logic                      r_rd_vld;
    logic [scl_pkg::IDX_W-1:0] r_rd_idx;
    scl_pkg::t_entry           r_rd_data;
    logic                      r_rd_ent_vld;

    // scan results
    logic                        r_hit;
    logic [scl_pkg::IDX_W-1:0]   r_found;
    logic [scl_pkg::IDX_W-1:0]   r_old;
    logic                        r_old_vld;
    logic [scl_pkg::STAMP_W-1:0] r_min;

    // output registers
    logic          r_out_vld;
    scl_pkg::t_rsp r_rsp;

    logic [scl_pkg::STAMP_W-1:0] w_stamp;
    logic                        w_match;
    logic [scl_pkg::IDX_W-1:0]   w_sel;

    assign o_sts.last_issue = (r_addr == scl_pkg::IDX_W'(scl_pkg::CACHE_ENTRIES - 1));

    // invalid entries read as stamp zero
    assign w_stamp = r_rd_ent_vld ? r_rd_data.stamp : '0;
    assign w_match = r_rd_ent_vld
                     && (r_rd_data.tag_x == r_req.slot_x)
                     && (r_rd_data.tag_z == r_req.slot_z);
    assign w_sel   = r_hit ? r_found : r_old;

    // memory read and write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data    <= r_mem[r_addr];
            r_rd_ent_vld <= r_ent_vld[r_addr];
            r_rd_idx     <= r_addr;
        end
        if (i_cmd.update) begin
            r_mem[w_sel] <= '{tag_x: r_req.slot_x, tag_z: r_req.slot_z,
                              stamp: r_req.frame_number};
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (i_cmd.update) begin
            r_ent_vld[w_sel] <= 1'b1;
        end
    end

    // scan address and read-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // query latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // first match and first oldest stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (r_rd_vld && !r_hit && w_match) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (!r_hit && w_match) begin
                r_found <= r_rd_idx;
            end
            if ((r_rd_idx == '0) || (w_stamp < r_min)) begin
                r_min     <= w_stamp;
                r_old     <= r_rd_idx;
                r_old_vld <= r_rd_ent_vld;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rsp.hit           <= r_hit;
            r_rsp.entry_index   <= scl_pkg::ENTRY_IDX_W'(w_sel);
            r_rsp.fill_needed   <= !r_hit;
            r_rsp.evicted_valid <= !r_hit && r_old_vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule
